// ----- hw/rtl/dual_channel_sequential_servo_pwm_assert.svh -----
// ----------------------------------------------------------------------------
// Servo PWM assertion macros
// Shared concurrent assertion forms on clk; SVPWM_ASSERT skips reset (rst_n).
// ----------------------------------------------------------------------------
`ifndef DUAL_CHANNEL_SEQUENTIAL_SERVO_PWM_ASSERT_SVH
`define DUAL_CHANNEL_SEQUENTIAL_SERVO_PWM_ASSERT_SVH

// property checked outside reset only
`define SVPWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define SVPWM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/svpwm_pkg.sv -----
// ----------------------------------------------------------------------------
// Servo PWM package
// Types, codes and reset values shared by the servo PWM block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svpwm_pkg;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_SERVO = 2'd1;
    localparam logic [1:0] FUNC_MOTOR = 2'd2;

    typedef enum logic [2:0] {
        REG_FRAME_PERIOD = 3'd0,
        REG_SERVO_CENTER = 3'd1,
        REG_SERVO_GAIN   = 3'd2,
        REG_SERVO_LIMIT  = 3'd3,
        REG_MOTOR_CENTER = 3'd4,
        REG_MOTOR_GAIN   = 3'd5,
        REG_MOTOR_LIMIT  = 3'd6
    } reg_idx_t;

    localparam logic [15:0] RST_FRAME_PERIOD = 16'd40000;
    localparam logic [14:0] RST_SERVO_CENTER = 15'd3000;
    localparam logic [7:0]  RST_SERVO_GAIN   = 8'd22;
    localparam logic [6:0]  RST_SERVO_LIMIT  = 7'd30;
    localparam logic [14:0] RST_MOTOR_CENTER = 15'd3000;
    localparam logic [7:0]  RST_MOTOR_GAIN   = 8'd26;
    localparam logic [6:0]  RST_MOTOR_LIMIT  = 7'd100;

    localparam logic [15:0] RST_WIDTH     = 16'd3000;
    localparam logic [15:0] RST_SERVO_END = 16'd3000;
    localparam logic [16:0] RST_MOTOR_END = 17'd6000;

    // x / 10 == (x * 52429) >> 19 for any 16-bit x
    localparam logic [16:0] DIV10_RECIP = 17'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef struct packed {
        logic [15:0] frame_period;
        logic [14:0] servo_center;
        logic [7:0]  servo_gain;
        logic [6:0]  servo_limit;
        logic [14:0] motor_center;
        logic [7:0]  motor_gain_tenths;
        logic [6:0]  motor_limit;
    } cfg_t;

    typedef struct packed {
        logic servo_out;
        logic motor_out;
        logic frame_start;
    } pins_t;

endpackage

// ----- hw/rtl/svpwm_if.sv -----
// ----------------------------------------------------------------------------
// Servo PWM channel interfaces
// Valid/ready channels for command words, result words and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface svpwm_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [15:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface svpwm_result_if;
    logic valid;
    logic ready;
    logic servo_out;
    logic motor_out;
    logic frame_start;

    modport source (output valid, output servo_out, output motor_out,
                    output frame_start, input ready);
    modport sink   (input valid, input servo_out, input motor_out,
                    input frame_start, output ready);
endinterface

interface svpwm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/svpwm_regs.sv -----
// ----------------------------------------------------------------------------
// Servo PWM register file
// Holds the seven configuration registers, written one word at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svpwm_regs (
    input  logic            clk,
    input  logic            rst_n,
    svpwm_cfg_if.sink       cfg,
    output svpwm_pkg::cfg_t regs
);
    import svpwm_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FRAME_PERIOD: regs_next.frame_period      = cfg.data;
                REG_SERVO_CENTER: regs_next.servo_center      = cfg.data[14:0];
                REG_SERVO_GAIN:   regs_next.servo_gain        = cfg.data[7:0];
                REG_SERVO_LIMIT:  regs_next.servo_limit       = cfg.data[6:0];
                REG_MOTOR_CENTER: regs_next.motor_center      = cfg.data[14:0];
                REG_MOTOR_GAIN:   regs_next.motor_gain_tenths = cfg.data[7:0];
                REG_MOTOR_LIMIT:  regs_next.motor_limit       = cfg.data[6:0];
                default:          regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.frame_period      <= RST_FRAME_PERIOD;
            regs_reg.servo_center      <= RST_SERVO_CENTER;
            regs_reg.servo_gain        <= RST_SERVO_GAIN;
            regs_reg.servo_limit       <= RST_SERVO_LIMIT;
            regs_reg.motor_center      <= RST_MOTOR_CENTER;
            regs_reg.motor_gain_tenths <= RST_MOTOR_GAIN;
            regs_reg.motor_limit       <= RST_MOTOR_LIMIT;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ----- hw/rtl/svpwm_cmd.sv -----
// ----------------------------------------------------------------------------
// Servo PWM width computation
// Clamps and scales set-servo / set-motor values into stored pulse widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svpwm_cmd (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic signed [15:0] value,
    input  svpwm_pkg::cfg_t    regs,
    input  logic               apply_servo,
    input  logic               apply_motor,
    output logic [15:0]        servo_width,
    output logic [15:0]        motor_width
);
    import svpwm_pkg::*;

    // input stage: clamped magnitude times gain, with sign
    logic [6:0]  servo_mag;
    logic        servo_neg;
    logic [6:0]  motor_mag;
    logic        motor_neg;
    logic [14:0] servo_prod_reg;
    logic        servo_neg_reg;
    logic [14:0] motor_prod_reg;
    logic        motor_neg_reg;
    logic [15:0] val_abs;

    // width stage
    logic [31:0]        div_prod;
    logic [11:0]        motor_q;
    logic signed [17:0] servo_diff;
    logic signed [16:0] motor_diff;
    logic [15:0]        servo_width_reg;
    logic [15:0]        servo_width_next;
    logic [15:0]        motor_width_reg;
    logic [15:0]        motor_width_next;

    assign val_abs = value[15] ? 16'(-value) : value;

    always_comb
    begin
        servo_neg = value[15];
        motor_neg = value[15];
        if (value > $signed({9'd0, regs.servo_limit}) ||
            value < -$signed({9'd0, regs.servo_limit}))
            servo_mag = regs.servo_limit;
        else
            servo_mag = val_abs[6:0];
        if (value > $signed({9'd0, regs.motor_limit}) ||
            value < -$signed({9'd0, regs.motor_limit}))
            motor_mag = regs.motor_limit;
        else
            motor_mag = val_abs[6:0];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            servo_prod_reg <= 15'(servo_mag * regs.servo_gain);
            servo_neg_reg  <= servo_neg;
            motor_prod_reg <= 15'(motor_mag * regs.motor_gain_tenths);
            motor_neg_reg  <= motor_neg;
        end
    end

    assign div_prod = 32'({17'd0, motor_prod_reg} * DIV10_RECIP);
    assign motor_q  = div_prod[DIV10_SHIFT +: 12];

    // width = center - gain * angle; a negative angle adds
    assign servo_diff = servo_neg_reg
                      ? $signed({3'd0, regs.servo_center}) + $signed({3'd0, servo_prod_reg})
                      : $signed({3'd0, regs.servo_center}) - $signed({3'd0, servo_prod_reg});
    assign motor_diff = motor_neg_reg
                      ? $signed({2'd0, regs.motor_center}) + $signed({5'd0, motor_q})
                      : $signed({2'd0, regs.motor_center}) - $signed({5'd0, motor_q});

    always_comb
    begin
        servo_width_next = servo_width_reg;
        motor_width_next = motor_width_reg;
        if (apply_servo)
        begin
            priority if (servo_diff < 0)
                servo_width_next = '0;
            else if (servo_diff > 18'sd65535)
                servo_width_next = '1;
            else
                servo_width_next = servo_diff[15:0];
        end
        if (apply_motor)
        begin
            priority if (motor_diff < 0)
                motor_width_next = '0;
            else
                motor_width_next = motor_diff[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_width_reg <= RST_WIDTH;
            motor_width_reg <= RST_WIDTH;
        end
        else
        begin
            servo_width_reg <= servo_width_next;
            motor_width_reg <= motor_width_next;
        end
    end

    assign servo_width = servo_width_reg;
    assign motor_width = motor_width_reg;

endmodule

// ----- hw/rtl/svpwm_frame.sv -----
// ----------------------------------------------------------------------------
// Servo PWM frame timer
// Tick counter, per-frame latching of pulse ends and pin levels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svpwm_frame #(
    parameter int COUNT_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tick,
    input  logic             step,
    input  logic [15:0]      frame_period,
    input  logic [15:0]      servo_width,
    input  logic [15:0]      motor_width,
    output svpwm_pkg::pins_t pins
);
    import svpwm_pkg::*;

    `include "dual_channel_sequential_servo_pwm_assert.svh"

    localparam int CMP_W = (COUNT_BITS > 17) ? COUNT_BITS : 17;

    logic [COUNT_BITS-1:0] tick_count_reg;
    logic [COUNT_BITS-1:0] tick_count_next;
    logic [COUNT_BITS-1:0] count_inc;
    logic [15:0]           servo_end_reg;
    logic [15:0]           servo_end_next;
    logic [16:0]           motor_end_reg;
    logic [16:0]           motor_end_next;
    logic                  servo_lvl_reg;
    logic                  servo_lvl_next;
    logic                  motor_lvl_reg;
    logic                  motor_lvl_next;
    logic                  at_start;
    logic [CMP_W-1:0]      pos;

    assign at_start  = (tick_count_reg == '0);
    assign pos       = CMP_W'(tick_count_reg);
    assign count_inc = tick_count_reg + 1'b1;

    always_comb
    begin
        tick_count_next = tick_count_reg;
        servo_end_next  = servo_end_reg;
        motor_end_next  = motor_end_reg;
        servo_lvl_next  = servo_lvl_reg;
        motor_lvl_next  = motor_lvl_reg;
        if (tick)
        begin
            if (at_start)
            begin
                servo_end_next = servo_width;
                motor_end_next = {1'b0, servo_width} + {1'b0, motor_width};
            end
            servo_lvl_next = (pos < CMP_W'(servo_end_next));
            motor_lvl_next = (pos >= CMP_W'(servo_end_next)) &&
                             (pos < CMP_W'(motor_end_next));
            // past or at the period (also period zero) wraps to a new frame
            if (CMP_W'(count_inc) >= CMP_W'(frame_period))
                tick_count_next = '0;
            else
                tick_count_next = count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            servo_end_reg  <= RST_SERVO_END;
            motor_end_reg  <= RST_MOTOR_END;
            servo_lvl_reg  <= 1'b0;
            motor_lvl_reg  <= 1'b0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
            servo_end_reg  <= servo_end_next;
            motor_end_reg  <= motor_end_next;
            servo_lvl_reg  <= servo_lvl_next;
            motor_lvl_reg  <= motor_lvl_next;
        end
    end

    assign pins.servo_out   = servo_lvl_next;
    assign pins.motor_out   = motor_lvl_next;
    assign pins.frame_start = tick && at_start;

    `SVPWM_ASSERT_ALWAYS(a_pins_exclusive, !(servo_lvl_reg && motor_lvl_reg),
        "servo and motor pins high together")
    `SVPWM_ASSERT(a_end_order, motor_end_reg >= {1'b0, servo_end_reg},
        "motor pulse end precedes servo pulse end")
    `SVPWM_ASSERT(a_count_hold, !tick |=> $stable(tick_count_reg),
        "tick counter moved on a non-tick word")
    `SVPWM_ASSERT(a_tick_is_step, tick |-> step,
        "tick applied outside a pipeline step")

endmodule

// ----- hw/rtl/dual_channel_sequential_servo_pwm.sv -----
// ----------------------------------------------------------------------------
// Dual-channel sequential servo PWM
// Two RC pulse outputs, one after the other in each frame, stepped by ticks.
// ----------------------------------------------------------------------------
// Channels: cmd takes one word per tick or set command (func, value); result
// returns one word per cmd word with both pin levels and a frame-start flag;
// cfg writes one register per word (index, data) and is always ready.
// Set-servo and set-motor words update the stored widths used from the next
// frame start; tick words advance the frame counter.
// Pipeline: a cmd word loads the input register when it is taken, and its
// result loads the result register when that word steps on. Throughput is
// one word per cycle while result is not held, set by the single
// width/frame stage between those two registers.
// Stall: while result is held, one more cmd word is taken into the input
// register; after that cmd.ready drops until the result word is taken.
// Reset: registers return to their defaults, widths to 3000 ticks, pins low,
// and the first tick word after reset starts a frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_channel_sequential_servo_pwm #(
    parameter int COUNT_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    svpwm_cmd_if.sink       cmd,
    svpwm_result_if.source  result,
    svpwm_cfg_if.sink       cfg
);
    import svpwm_pkg::*;

    cfg_t       regs;
    pins_t      pins;
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [1:0] s1_func_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    pins_t      out_pins_reg;
    logic       advance;
    logic       take;
    logic       step;
    logic [15:0] servo_width;
    logic [15:0] motor_width;

    assign advance   = !out_valid_reg || result.ready;
    assign cmd.ready = !s1_valid_reg || advance;
    assign take      = cmd.valid && cmd.ready;
    assign step      = s1_valid_reg && advance;

    svpwm_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    svpwm_cmd u_cmd (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (take),
        .value       (cmd.value),
        .regs        (regs),
        .apply_servo (step && (s1_func_reg == FUNC_SERVO)),
        .apply_motor (step && (s1_func_reg == FUNC_MOTOR)),
        .servo_width (servo_width),
        .motor_width (motor_width)
    );

    svpwm_frame #(
        .COUNT_BITS (COUNT_BITS)
    ) u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (step && (s1_func_reg == FUNC_TICK)),
        .step         (step),
        .frame_period (regs.frame_period),
        .servo_width  (servo_width),
        .motor_width  (motor_width),
        .pins         (pins)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            s1_func_reg <= cmd.func;
        if (step)
            out_pins_reg <= pins;
    end

    assign result.valid       = out_valid_reg;
    assign result.servo_out   = out_pins_reg.servo_out;
    assign result.motor_out   = out_pins_reg.motor_out;
    assign result.frame_start = out_pins_reg.frame_start;

endmodule
